// ===== rtl/core/rtpfua_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package rtpfua_pkg;

    localparam int LENGTH_BITS    = 24;
    localparam int MAX_BITS       = 16;
    localparam int PT_BITS        = 7;
    localparam int SEQ_BITS       = 16;
    localparam int TS_BITS        = 32;
    localparam int SSRC_BITS      = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int POS_BITS       = 4;

    typedef logic [LENGTH_BITS-1:0]    len_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [POS_BITS-1:0]       pos_t;

    localparam cfg_index_t CFG_MAX_PAYLOAD  = 2'd0;
    localparam cfg_index_t CFG_PAYLOAD_TYPE = 2'd1;
    localparam cfg_index_t CFG_SSRC         = 2'd2;

    localparam logic [MAX_BITS-1:0] MAX_PAYLOAD_RESET  = 16'd1200;
    localparam logic [PT_BITS-1:0]  PAYLOAD_TYPE_RESET = 7'd96;
    localparam logic [MAX_BITS-1:0] MIN_PAYLOAD        = 16'd3;
    localparam logic [MAX_BITS-1:0] FU_OVERHEAD        = 16'd2;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] FU_START_BIT     = 8'h80;
    localparam logic [7:0] FU_END_BIT       = 8'h40;
    localparam logic [7:0] NAL_TYPE_MASK    = 8'h1f;
    localparam logic [7:0] NAL_NRI_MASK     = 8'he0;
    localparam logic [7:0] FU_A_TYPE        = 8'd28;

    localparam pos_t POS_FIRST    = 4'd0;
    localparam pos_t POS_HDR_LAST = 4'd11;
    localparam pos_t POS_FU_IND   = 4'd12;
    localparam pos_t POS_FU_HDR   = 4'd13;
    localparam pos_t POS_DATA     = 4'd14;

    typedef struct packed {
        logic [MAX_BITS-1:0]  max_payload_bytes;
        logic [PT_BITS-1:0]   rtp_pt;
        logic [SSRC_BITS-1:0] stream_ssrc;
    } cfg_t;

    typedef struct packed {
        logic [7:0]          nal_byte;
        len_t                nal_length;
        logic                unit_last;
        logic [TS_BITS-1:0]  unit_stamp;
    } nal_item_t;

    typedef struct packed {
        logic                has_header;
        logic                has_fu;
        logic                marker;
        logic [SEQ_BITS-1:0] seq;
        logic [TS_BITS-1:0]  timestamp;
        logic [7:0]          fu_indicator;
        logic [7:0]          fu_header;
        logic [7:0]          data_byte;
        logic                data_end;
    } job_t;

endpackage

// ===== rtl/core/rtpfua_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_in_if
// NAL byte channel: valid, ready and one NAL unit byte with unit fields.
// ----------------------------------------------------------------------------
interface rtpfua_in_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         nal_byte;
    logic [rtpfua_pkg::LENGTH_BITS-1:0] nal_length;
    logic                               unit_last;
    logic [rtpfua_pkg::TS_BITS-1:0]     unit_stamp;

    modport source (output valid, nal_byte, nal_length, unit_last, unit_stamp,
                    input ready);
    modport sink (input valid, nal_byte, nal_length, unit_last, unit_stamp,
                  output ready);
endinterface

// ===== rtl/core/rtpfua_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_out_if
// RTP byte channel: valid, ready and one packet byte with framing flags.
// ----------------------------------------------------------------------------
interface rtpfua_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;

    modport source (output valid, out_byte, packet_start, packet_end, run_last,
                    input ready);
    modport sink (input valid, out_byte, packet_start, packet_end, run_last,
                  output ready);
endinterface

// ===== rtl/core/rtpfua_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_cfg_if
// Configuration write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface rtpfua_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rtpfua_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rtpfua_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rtpfua_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_cfg_regs
// Configuration registers: max payload size, payload type and SSRC.
// ----------------------------------------------------------------------------
module rtpfua_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    rtpfua_cfg_if.sink        cfg,
    output rtpfua_pkg::cfg_t  cfg_val
);
    import rtpfua_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (cfg.index == CFG_MAX_PAYLOAD)
            begin
                cfg_next.max_payload_bytes = cfg.data[MAX_BITS-1:0];
            end
            else if (cfg.index == CFG_PAYLOAD_TYPE)
            begin
                cfg_next.rtp_pt = cfg.data[PT_BITS-1:0];
            end
            else if (cfg.index == CFG_SSRC)
            begin
                cfg_next.stream_ssrc = cfg.data[SSRC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_bytes <= MAX_PAYLOAD_RESET;
            cfg_reg.rtp_pt            <= PAYLOAD_TYPE_RESET;
            cfg_reg.stream_ssrc       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

// ===== rtl/core/rtpfua_planner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_planner
// Per-byte packet planning: unit state, fragment bounds, sequence numbering.
// ----------------------------------------------------------------------------
module rtpfua_planner (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rtpfua_pkg::nal_item_t item,
    input  rtpfua_pkg::cfg_t      cfg_val,
    output logic                  job_valid,
    output rtpfua_pkg::job_t      job
);
    import rtpfua_pkg::*;

    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    len_t                off_reg, off_next;
    len_t                len_reg, len_next;
    len_t                fend_reg, fend_next;
    logic                frag_reg, frag_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic [TS_BITS-1:0]  ts_reg, ts_next;
    logic                mark_reg, mark_next;

    logic [MAX_BITS-1:0] eff_max;
    len_t                len_fix;
    logic                first;
    logic                fits;
    logic                frag_start;
    logic [LENGTH_BITS:0] off_inc;
    logic [LENGTH_BITS:0] frag_sum;
    len_t                frag_end_new;
    logic                frag_last;
    len_t                len_cur;
    len_t                fend_eff;

    assign eff_max  = (cfg_val.max_payload_bytes < MIN_PAYLOAD) ? MIN_PAYLOAD
                                                                 : cfg_val.max_payload_bytes;
    assign len_fix  = (item.nal_length == '0) ? len_t'(1) : item.nal_length;
    assign first    = (off_reg == '0);
    assign fits     = (len_fix <= len_t'(eff_max));
    assign off_inc  = {1'b0, off_reg} + (LENGTH_BITS+1)'(1);
    assign frag_sum = {1'b0, off_reg} + (LENGTH_BITS+1)'(eff_max - FU_OVERHEAD);
    assign frag_end_new = (frag_sum > {1'b0, len_reg}) ? len_reg
                                                      : frag_sum[LENGTH_BITS-1:0];
    assign frag_last  = (frag_end_new == len_reg);
    assign frag_start = !first && frag_reg && (off_reg == fend_reg);
    assign len_cur    = first ? len_fix : len_reg;
    assign fend_eff   = first ? len_fix : (frag_start ? frag_end_new : fend_reg);

    always_comb
    begin
        seq_next  = seq_reg;
        off_next  = off_reg;
        len_next  = len_reg;
        fend_next = fend_reg;
        frag_next = frag_reg;
        hdr_next  = hdr_reg;
        ts_next   = ts_reg;
        mark_next = mark_reg;

        job_valid        = 1'b0;
        job.has_header   = 1'b0;
        job.has_fu       = 1'b0;
        job.marker       = 1'b0;
        job.seq          = seq_reg;
        job.timestamp    = first ? item.unit_stamp : ts_reg;
        job.fu_indicator = (hdr_reg & NAL_NRI_MASK) | FU_A_TYPE;
        job.fu_header    = (off_reg == len_t'(1) ? FU_START_BIT : 8'h00)
                         | (frag_last ? FU_END_BIT : 8'h00)
                         | (hdr_reg & NAL_TYPE_MASK);
        job.data_byte    = item.nal_byte;
        job.data_end     = (off_inc == {1'b0, fend_eff});

        if (accept)
        begin
            if (first)
            begin
                len_next  = len_fix;
                ts_next   = item.unit_stamp;
                mark_next = item.unit_last;
                hdr_next  = item.nal_byte;
                if (fits)
                begin
                    frag_next      = 1'b0;
                    fend_next      = len_fix;
                    job_valid      = 1'b1;
                    job.has_header = 1'b1;
                    job.marker     = item.unit_last;
                    seq_next       = seq_reg + SEQ_BITS'(1);
                end
                else
                begin
                    frag_next = 1'b1;
                    fend_next = len_t'(1);
                end
            end
            else
            begin
                job_valid = 1'b1;
                if (frag_start)
                begin
                    fend_next      = frag_end_new;
                    job.has_header = 1'b1;
                    job.has_fu     = 1'b1;
                    job.marker     = frag_last && mark_reg;
                    seq_next       = seq_reg + SEQ_BITS'(1);
                end
            end
            off_next = (off_inc >= {1'b0, len_cur}) ? '0 : off_inc[LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            off_reg  <= '0;
            len_reg  <= '0;
            fend_reg <= '0;
            frag_reg <= 1'b0;
            hdr_reg  <= '0;
            ts_reg   <= '0;
            mark_reg <= 1'b0;
        end
        else
        begin
            seq_reg  <= seq_next;
            off_reg  <= off_next;
            len_reg  <= len_next;
            fend_reg <= fend_next;
            frag_reg <= frag_next;
            hdr_reg  <= hdr_next;
            ts_reg   <= ts_next;
            mark_reg <= mark_next;
        end
    end
endmodule

// ===== rtl/core/rtpfua_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpfua_emitter
// Two-slot job buffer and byte sequencer: RTP header, FU bytes, data byte.
// ----------------------------------------------------------------------------
module rtpfua_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  rtpfua_pkg::job_t  job,
    output logic              job_ready,
    input  rtpfua_pkg::cfg_t  cfg_val,
    rtpfua_out_if.source      rtp
);
    import rtpfua_pkg::*;

    logic pend_valid_reg, pend_valid_next;
    job_t pend_reg, pend_next;
    logic act_valid_reg, act_valid_next;
    job_t act_reg, act_next;
    pos_t pos_reg, pos_next;

    logic out_fire;
    logic act_done;
    logic act_free;
    logic pend_take;
    logic load_direct;

    assign out_fire    = act_valid_reg && rtp.ready;
    assign act_done    = out_fire && (pos_reg == POS_DATA);
    assign act_free    = !act_valid_reg || act_done;
    assign pend_take   = pend_valid_reg && act_free;
    assign load_direct = job_valid && act_free && !pend_valid_reg;
    assign job_ready   = !pend_valid_reg || pend_take;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        act_valid_next  = act_valid_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;

        if (pend_take)
        begin
            act_valid_next  = 1'b1;
            act_next        = pend_reg;
            pos_next        = pend_reg.has_header ? POS_FIRST : POS_DATA;
            pend_valid_next = job_valid;
            pend_next       = job;
        end
        else
        begin
            if (load_direct)
            begin
                act_valid_next = 1'b1;
                act_next       = job;
                pos_next       = job.has_header ? POS_FIRST : POS_DATA;
            end
            else
            begin
                if (act_done)
                begin
                    act_valid_next = 1'b0;
                end
                else if (out_fire)
                begin
                    pos_next = (pos_reg == POS_HDR_LAST && !act_reg.has_fu)
                             ? POS_DATA : pos_reg + POS_BITS'(1);
                end
                if (job_valid)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = job;
                end
            end
        end
    end

    always_comb
    begin
        unique case (pos_reg)
            4'd0:  rtp.out_byte = RTP_VERSION_BYTE;
            4'd1:  rtp.out_byte = {act_reg.marker, cfg_val.rtp_pt};
            4'd2:  rtp.out_byte = act_reg.seq[15:8];
            4'd3:  rtp.out_byte = act_reg.seq[7:0];
            4'd4:  rtp.out_byte = act_reg.timestamp[31:24];
            4'd5:  rtp.out_byte = act_reg.timestamp[23:16];
            4'd6:  rtp.out_byte = act_reg.timestamp[15:8];
            4'd7:  rtp.out_byte = act_reg.timestamp[7:0];
            4'd8:  rtp.out_byte = cfg_val.stream_ssrc[31:24];
            4'd9:  rtp.out_byte = cfg_val.stream_ssrc[23:16];
            4'd10: rtp.out_byte = cfg_val.stream_ssrc[15:8];
            4'd11: rtp.out_byte = cfg_val.stream_ssrc[7:0];
            4'd12: rtp.out_byte = act_reg.fu_indicator;
            4'd13: rtp.out_byte = act_reg.fu_header;
            4'd14: rtp.out_byte = act_reg.data_byte;
            default: rtp.out_byte = 8'h00;
        endcase
    end

    assign rtp.valid        = act_valid_reg;
    assign rtp.packet_start = (pos_reg == POS_FIRST);
    assign rtp.packet_end   = (pos_reg == POS_DATA) && act_reg.data_end;
    assign rtp.run_last     = (pos_reg == POS_DATA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            pos_reg        <= POS_FIRST;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        act_reg  <= act_next;
    end
endmodule

// ===== rtl/core/h264_rtp_fu_a_packetizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// H.264 RTP packetizer, single NAL unit and FU-A modes, one NAL byte per item.
// Accepted items are registered in the emitter's job slots before their bytes go out.
// Throughput: 1 output byte per cycle while rtp.ready is high; a plain byte item
// emits 1 byte, a packet-starting item emits 13 bytes (single NAL) or 15 (FU-A).
// A two-slot job buffer lets the next item enter while the current one drains.
// Reset: asynchronous, active low; clears unit state, sequence number, buffers.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer (
    input  logic          clk,
    input  logic          rst_n,
    rtpfua_in_if.sink     nal,
    rtpfua_out_if.source  rtp,
    rtpfua_cfg_if.sink    cfg
);
    import rtpfua_pkg::*;

    cfg_t      cfg_val;
    nal_item_t item;
    job_t      job;
    logic      job_valid;
    logic      job_ready;
    logic      accept;

    assign item.nal_byte   = nal.nal_byte;
    assign item.nal_length = nal.nal_length;
    assign item.unit_last  = nal.unit_last;
    assign item.unit_stamp = nal.unit_stamp;
    assign nal.ready       = job_ready;
    assign accept          = nal.valid && job_ready;

    rtpfua_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    rtpfua_planner u_planner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_val   (cfg_val),
        .job_valid (job_valid),
        .job       (job)
    );

    rtpfua_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .cfg_val   (cfg_val),
        .rtp       (rtp)
    );
endmodule

// ===== dv/h264_rtp_fu_a_packetizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer_test
// Feeds NAL unit bytes into the RTP FU-A packetizer, with random idle cycles
// on the input and random stalls on the output. Each accepted byte updates a
// packetizer predictor that queues the packet bytes it should produce: the RTP
// header, the FU indicator and FU header, and the data. Every output item is
// compared field by field, in order, with the oldest predicted byte. Register
// settings change between phases, and once in the middle of a unit.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_packetizer_test;
    import rtpfua_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 8;
    localparam int MAX_GAP          = 6;
    localparam int SETTLE_CYCLES    = 40;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int RANDOM_PHASES    = 5;
    localparam int PHASE_ITEMS      = 48;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam cfg_index_t CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       run_last;
    } rtp_byte_t;

    class rtp_packet_scoreboard;
        logic [MAX_BITS-1:0]  max_payload;
        logic [PT_BITS-1:0]   rtp_pt;
        logic [SSRC_BITS-1:0] ssrc;
        logic [SEQ_BITS-1:0]  seq_number;
        len_t                 byte_offset;
        len_t                 held_length;
        len_t                 fragment_end;
        logic                 fragment_mode;
        logic [7:0]           held_header;
        logic [TS_BITS-1:0]   held_timestamp;
        logic                 held_marker;
        rtp_byte_t            packet_bytes[$];
        int                   mismatches;

        function new();
            max_payload    = MAX_PAYLOAD_RESET;
            rtp_pt         = PAYLOAD_TYPE_RESET;
            ssrc           = '0;
            seq_number     = '0;
            byte_offset    = '0;
            held_length    = '0;
            fragment_end   = '0;
            fragment_mode  = 1'b0;
            held_header    = '0;
            held_timestamp = '0;
            held_marker    = 1'b0;
            mismatches     = 0;
        endfunction

        function void write_register(cfg_index_t index, logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_MAX_PAYLOAD:  max_payload = data[MAX_BITS-1:0];
                CFG_PAYLOAD_TYPE: rtp_pt      = data[PT_BITS-1:0];
                CFG_SSRC:         ssrc        = data[SSRC_BITS-1:0];
                default:          ;
            endcase
        endfunction

        function int pending();
            return packet_bytes.size();
        endfunction

        function void push_byte(logic [7:0] value, logic opening, logic closing);
            rtp_byte_t entry;
            entry.out_byte     = value;
            entry.packet_start = opening;
            entry.packet_end   = closing;
            entry.run_last     = 1'b0;
            packet_bytes.insert(packet_bytes.size(), entry);
        endfunction

        function void push_header(logic marker);
            push_byte(RTP_VERSION_BYTE, 1'b1, 1'b0);
            push_byte({marker, rtp_pt}, 1'b0, 1'b0);
            push_byte(seq_number[15:8], 1'b0, 1'b0);
            push_byte(seq_number[7:0], 1'b0, 1'b0);
            push_byte(held_timestamp[31:24], 1'b0, 1'b0);
            push_byte(held_timestamp[23:16], 1'b0, 1'b0);
            push_byte(held_timestamp[15:8], 1'b0, 1'b0);
            push_byte(held_timestamp[7:0], 1'b0, 1'b0);
            push_byte(ssrc[31:24], 1'b0, 1'b0);
            push_byte(ssrc[23:16], 1'b0, 1'b0);
            push_byte(ssrc[15:8], 1'b0, 1'b0);
            push_byte(ssrc[7:0], 1'b0, 1'b0);
            seq_number = seq_number + SEQ_BITS'(1);
        endfunction

        function void note_input(nal_item_t item);
            int unsigned payload_limit;
            int unsigned offset;
            int unsigned unit_len;
            int unsigned stop;
            int unsigned queued;
            logic        opening;
            logic        closing;
            payload_limit = 32'((max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload);
            offset = 32'(byte_offset);
            queued = packet_bytes.size();
            if (offset == 0)
            begin
                unit_len = (item.nal_length == '0) ? 1 : 32'(item.nal_length);
                held_length    = len_t'(unit_len);
                held_timestamp = item.unit_stamp;
                held_marker    = item.unit_last;
                held_header    = item.nal_byte;
                if (unit_len <= payload_limit)
                begin
                    fragment_mode = 1'b0;
                    fragment_end  = len_t'(unit_len);
                    push_header(held_marker);
                    push_byte(item.nal_byte, 1'b0, unit_len == 1);
                end
                else
                begin
                    fragment_mode = 1'b1;
                    fragment_end  = len_t'(1);
                end
            end
            else
            begin
                if (fragment_mode && offset == 32'(fragment_end))
                begin
                    opening = (offset == 1);
                    stop = offset + payload_limit - 32'(FU_OVERHEAD);
                    if (stop > 32'(held_length))
                        stop = 32'(held_length);
                    closing = (stop == 32'(held_length));
                    fragment_end = len_t'(stop);
                    push_header(closing && held_marker);
                    push_byte((held_header & NAL_NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
                    push_byte((opening ? FU_START_BIT : 8'h00) | (closing ? FU_END_BIT : 8'h00)
                              | (held_header & NAL_TYPE_MASK), 1'b0, 1'b0);
                end
                push_byte(item.nal_byte, 1'b0, offset + 1 == 32'(fragment_end));
            end
            byte_offset = (offset + 1 >= 32'(held_length)) ? len_t'(0) : len_t'(offset + 1);
            if (packet_bytes.size() > queued)
                packet_bytes[packet_bytes.size() - 1].run_last = 1'b1;
        endfunction

        function void compare_field(string name, logic [7:0] wanted, logic [7:0] seen);
            if (seen !== wanted)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, wanted, seen);
                mismatches++;
            end
        endfunction

        function void check_result(rtp_byte_t actual);
            rtp_byte_t wanted;
            if (packet_bytes.size() == 0)
            begin
                $display("%0t: out_byte expected none actual %0h", $time, actual.out_byte);
                mismatches++;
            end
            else
            begin
                wanted = packet_bytes.pop_front();
                compare_field("out_byte", wanted.out_byte, actual.out_byte);
                compare_field("packet_start", 8'(wanted.packet_start),
                              8'(actual.packet_start));
                compare_field("packet_end", 8'(wanted.packet_end), 8'(actual.packet_end));
                compare_field("run_last", 8'(wanted.run_last), 8'(actual.run_last));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   items_sent    = 0;
    int   receiver_hold = 0;

    rtp_packet_scoreboard packets = new();

    rtpfua_in_if  nal_ch();
    rtpfua_out_if rtp_ch();
    rtpfua_cfg_if cfg_ch();

    h264_rtp_fu_a_packetizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .nal   (nal_ch),
        .rtp   (rtp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int        stall;
        logic      calm;
        rtp_byte_t seen;
        rtp_ch.ready <= 1'b0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (receiver_hold > 0)
            begin
                stall = receiver_hold;
                receiver_hold = 0;
            end
            else
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rtp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rtp_ch.ready <= 1'b1;
            do @(posedge clk); while (rtp_ch.valid !== 1'b1);
            seen.out_byte     = rtp_ch.out_byte;
            seen.packet_start = rtp_ch.packet_start;
            seen.packet_end   = rtp_ch.packet_end;
            seen.run_last     = rtp_ch.run_last;
            packets.check_result(seen);
            if ($urandom_range(0, 29) == 0)
                calm = ~calm;
        end
    end

    task automatic send_item(input nal_item_t item, input logic calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            nal_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        nal_ch.valid      <= 1'b1;
        nal_ch.nal_byte   <= item.nal_byte;
        nal_ch.nal_length <= item.nal_length;
        nal_ch.unit_last  <= item.unit_last;
        nal_ch.unit_stamp <= item.unit_stamp;
        do @(posedge clk); while (nal_ch.ready !== 1'b1);
        packets.note_input(item);
        items_sent++;
    endtask

    // unit fields ride on the first byte; later bytes carry noise there
    task automatic send_unit(input len_t length_field, input int unsigned count,
                             input logic last, input logic [TS_BITS-1:0] stamp,
                             input logic [7:0] header);
        nal_item_t item;
        logic      calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < count; i++)
        begin
            item.nal_byte   = (i == 0) ? header : 8'($urandom);
            item.nal_length = (i == 0) ? length_field : len_t'($urandom);
            item.unit_last  = (i == 0) ? last : 1'($urandom);
            item.unit_stamp = (i == 0) ? stamp : $urandom;
            send_item(item, calm);
        end
    endtask

    task automatic wait_drained();
        nal_ch.valid <= 1'b0;
        while (packets.pending() != 0)
            @(posedge clk);
    endtask

    // the FU-A header byte leaves nothing queued, so settle past the drain
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(input logic [CFG_DATA_BITS-1:0] max_data,
                                   input logic [CFG_DATA_BITS-1:0] type_data,
                                   input logic [CFG_DATA_BITS-1:0] ssrc_data,
                                   input logic with_unused);
        cfg_index_t                index_list [4];
        logic [CFG_DATA_BITS-1:0]  data_list [4];
        int                        count;
        index_list = '{CFG_MAX_PAYLOAD, CFG_PAYLOAD_TYPE, CFG_SSRC, CFG_UNUSED};
        data_list  = '{max_data, type_data, ssrc_data, $urandom};
        count = with_unused ? 4 : 3;
        for (int i = 0; i < count; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= index_list[i];
            cfg_ch.data  <= data_list[i];
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            packets.write_register(index_list[i], data_list[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase_max;
        int unsigned unit_len;
        int unsigned unit_cap;
        int          target;
        int          waited;
        logic        paused;
        rst_n             <= 1'b0;
        nal_ch.valid      <= 1'b0;
        nal_ch.nal_byte   <= '0;
        nal_ch.nal_length <= '0;
        nal_ch.unit_last  <= 1'b0;
        nal_ch.unit_stamp <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_MAX_PAYLOAD;
        cfg_ch.data       <= '0;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_unit(24'd1, 1, 1'b1, 32'hffff_ffff, 8'hff);
        send_unit(24'd0, 1, 1'b0, 32'h0000_0000, 8'h00);
        send_unit(24'd3, 3, 1'b1, $urandom, 8'h65);
        wait_idle();
        write_registers(32'd3, 32'd127, 32'hffff_ffff, 1'b1);
        send_unit(24'd3, 3, 1'b0, $urandom, 8'h41);
        send_unit(24'd5, 5, 1'b1, $urandom, 8'hff);
        wait_idle();
        write_registers({16'($urandom), 16'd4}, {25'($urandom), 7'd0}, 32'd0, 1'b0);
        send_unit(24'd8, 3, 1'b1, $urandom, 8'h7c);
        wait_idle();
        write_registers(32'd6, 32'd0, 32'd0, 1'b0);
        send_unit(24'd8, 5, 1'b0, $urandom, 8'($urandom));
        wait_idle();
        write_registers(32'd1, $urandom, $urandom, 1'b0);
        send_unit(24'd4, 4, 1'b1, $urandom, 8'h9c);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       phase_max = $urandom_range(3, 12);
                1:       phase_max = $urandom_range(13, 40);
                2:       phase_max = 65535;
                3:       phase_max = $urandom_range(3, 6);
                default: phase_max = $urandom_range(41, 59);
            endcase
            write_registers({16'($urandom), 16'(phase_max)}, $urandom, $urandom, 1'b0);
            if (phase == 0)
                receiver_hold = LONG_HOLD_CYCLES;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if (phase_max >= 60 || $urandom_range(0, 3) == 0)
                    unit_len = $urandom_range(1, (phase_max < 60) ? phase_max : 60);
                else
                begin
                    unit_cap = (3 * phase_max + 2 < 90) ? 3 * phase_max + 2 : 90;
                    unit_len = $urandom_range(phase_max + 1, unit_cap);
                end
                if (phase == 1 && !paused && unit_len > 2)
                begin
                    // hold the input mid-unit until the output is empty
                    paused = 1'b1;
                    send_unit(len_t'(unit_len), 2, 1'($urandom), $urandom, 8'($urandom));
                    wait_drained();
                    send_unit(len_t'(unit_len), unit_len - 2, 1'($urandom), $urandom,
                              8'($urandom));
                end
                else
                    send_unit(len_t'(unit_len), unit_len, 1'($urandom), $urandom, 8'($urandom));
            end
        end

        wait_idle();
        send_unit(24'hff_ffff, 20, 1'($urandom), $urandom, 8'($urandom));
        nal_ch.valid <= 1'b0;
        waited = 0;
        while (packets.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (packets.pending() != 0)
            $display("%0t: %0d predicted bytes never arrived", $time, packets.pending());
        if (packets.mismatches == 0 && packets.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
